### hw/rtl/ptph_pkg.sv
// ----------------------------------------------------------------------------
// ptph_pkg: shared constants for the time-proportioned PID heater
// Register indexes, configuration port widths and field widths.
// ----------------------------------------------------------------------------
package ptph_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P          = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I          = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D          = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_GAIN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_OFFSET = 3'd4;

    localparam int GAIN_W   = 8;
    localparam int SPG_W    = 10;
    localparam int RAW_W    = 10;
    localparam int MEAS_W   = 9;
    localparam int SP_W     = 10;
    localparam int ERR_W    = 12;
    localparam int DIFF_W   = 10;
    localparam int TERM_W   = 20;
    localparam int SPPROD_W = 20;
    localparam int VAL_W    = 16;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 56;

    typedef enum logic {
        FUNC_TICK   = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

endpackage

### hw/rtl/pid_time_proportional_heater.sv
// ----------------------------------------------------------------------------
// pid_time_proportional_heater: PID temperature loop with windowed heater
// A request on the slave stream is either a timer tick (tuser low) or a new
// setpoint/sensor pair (tuser high). A sample request scales the setpoint,
// halves the sensor reading and runs the PID terms through bit-serial
// shift-and-add multipliers; a tick request reports the heater level for the
// current slot of the window and advances the slot. Every request yields
// exactly one result request on the master stream.
// A sample runs through the setpoint scale multiply (one multiplier bit per
// cycle), the error, the three gain multiplies run side by side, then
// saturation, sum, window threshold and result load; a tick goes straight to
// the result load. One request is worked on at a time. The result sits in an
// output register, so a stalled receiver holds only that request; a new
// request is accepted meanwhile and its result waits until the register is
// free.
// Reset: gains return to 1, setpoint gain to 48, offset to 32; slot,
// integral, last reading, control value and held values clear to zero.
// Configuration writes are taken in any cycle, with no read-back.
// ----------------------------------------------------------------------------
module pid_time_proportional_heater #(
    parameter int WINDOW_SLOTS       = 19,
    parameter int CONTROL_FULL_SCALE = 1020
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_we,
    input  logic [ptph_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ptph_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [9:0] measured_raw, [19:10] setpoint_raw, [23:20] zero
    input  logic [ptph_pkg::S_DATA_W-1:0]    s_tdata,
    // [0] func
    input  logic                             s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] heater_on, [10:1] setpoint_scaled, [19:11] measured,
    // [35:20] error_value, [51:36] control_value, [55:52] zero
    output logic [ptph_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int SLOT_W  = $clog2(WINDOW_SLOTS + 1);
    localparam int CLAMP_W = $clog2(CONTROL_FULL_SCALE + 1);
    localparam int PROD_W  = $clog2(CONTROL_FULL_SCALE * WINDOW_SLOTS + 1);
    localparam int CNT_W   = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ERROR,
        ST_TERMS,
        ST_SUM,
        ST_CTRL,
        ST_THRESH,
        ST_RESULT
    } state_t;

    function automatic logic signed [ptph_pkg::VAL_W-1:0] sat16(input logic signed [20:0] v);
        logic signed [ptph_pkg::VAL_W-1:0] r;
        if (v > 21'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    state_t                              state_reg;
    logic [CNT_W-1:0]                    cnt_reg;

    logic [ptph_pkg::GAIN_W-1:0]         gain_p_reg, gain_i_reg, gain_d_reg;
    logic [ptph_pkg::SPG_W-1:0]          sp_gain_reg;
    logic [ptph_pkg::GAIN_W-1:0]         sp_offset_reg;

    logic [SLOT_W-1:0]                   slot_reg;
    logic signed [ptph_pkg::VAL_W-1:0]   integral_reg;
    logic [ptph_pkg::MEAS_W-1:0]         last_meas_reg;
    logic signed [ptph_pkg::VAL_W-1:0]   control_reg;
    logic [ptph_pkg::SP_W-1:0]           held_sp_reg;
    logic signed [ptph_pkg::ERR_W-1:0]   held_err_reg;
    logic [PROD_W-1:0]                   csw_reg;

    logic [ptph_pkg::MEAS_W-1:0]         meas_reg;
    logic [ptph_pkg::SPPROD_W-1:0]       sp_mcand_reg;
    logic [ptph_pkg::SPG_W-1:0]          sp_mplier_reg;
    logic [ptph_pkg::SPPROD_W-1:0]       sp_acc_reg;

    logic signed [ptph_pkg::TERM_W-1:0]  err_sh_reg, diff_sh_reg;
    logic [ptph_pkg::GAIN_W-1:0]         gp_sh_reg, gi_sh_reg, gd_sh_reg;
    logic signed [ptph_pkg::TERM_W-1:0]  p_acc_reg, i_acc_reg, d_acc_reg;
    logic signed [ptph_pkg::VAL_W-1:0]   p_sat_reg, d_sat_reg;

    logic                                tick_reg;
    logic                                m_tvalid_reg;
    logic [ptph_pkg::M_DATA_W-1:0]       m_tdata_reg;

    logic [ptph_pkg::SP_W:0]             sp_sum;
    logic [ptph_pkg::SP_W-1:0]           sp_next;
    logic signed [ptph_pkg::ERR_W-1:0]   err_next;
    logic signed [ptph_pkg::DIFF_W-1:0]  diff_next;
    logic signed [20:0]                  integral_sum;
    logic signed [20:0]                  control_sum;
    logic [CLAMP_W-1:0]                  clamp_value;
    logic [PROD_W-1:0]                   csw_next;
    logic [PROD_W-1:0]                   slot_weight;
    logic                                heater_next;
    logic [SLOT_W-1:0]                   slot_next;
    logic                                out_free;

    always_comb begin
        sp_sum    = {1'b0, sp_acc_reg[ptph_pkg::SPPROD_W-1:ptph_pkg::SPG_W]}
                  + (ptph_pkg::SP_W+1)'(sp_offset_reg);
        sp_next   = sp_sum[ptph_pkg::SP_W] ? '1 : sp_sum[ptph_pkg::SP_W-1:0];
        err_next  = $signed({2'b00, sp_next}) - $signed({3'b000, meas_reg});
        diff_next = $signed({1'b0, last_meas_reg}) - $signed({1'b0, meas_reg});

        integral_sum = {{5{integral_reg[15]}}, integral_reg} + {i_acc_reg[19], i_acc_reg};
        control_sum  = {{5{p_sat_reg[15]}}, p_sat_reg}
                     + {{5{integral_reg[15]}}, integral_reg}
                     + {{5{d_sat_reg[15]}}, d_sat_reg};

        if (control_reg[15]) begin
            clamp_value = '0;
        end else if (control_reg[14:0] > 15'(CONTROL_FULL_SCALE)) begin
            clamp_value = CLAMP_W'(CONTROL_FULL_SCALE);
        end else begin
            clamp_value = CLAMP_W'(control_reg[14:0]);
        end
        csw_next = PROD_W'(clamp_value) * PROD_W'(WINDOW_SLOTS);

        slot_weight = PROD_W'(slot_reg) * PROD_W'(CONTROL_FULL_SCALE);
        heater_next = (slot_weight <= csw_reg);
        slot_next   = (slot_reg == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : slot_reg + 1'b1;

        out_free = !m_tvalid_reg || m_tready;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= ptph_pkg::GAIN_W'(1);
            gain_i_reg    <= ptph_pkg::GAIN_W'(1);
            gain_d_reg    <= ptph_pkg::GAIN_W'(1);
            sp_gain_reg   <= ptph_pkg::SPG_W'(48);
            sp_offset_reg <= ptph_pkg::GAIN_W'(32);
        end else if (cfg_we) begin
            case (cfg_addr)
                ptph_pkg::REG_GAIN_P:          gain_p_reg    <= cfg_wdata[ptph_pkg::GAIN_W-1:0];
                ptph_pkg::REG_GAIN_I:          gain_i_reg    <= cfg_wdata[ptph_pkg::GAIN_W-1:0];
                ptph_pkg::REG_GAIN_D:          gain_d_reg    <= cfg_wdata[ptph_pkg::GAIN_W-1:0];
                ptph_pkg::REG_SETPOINT_GAIN:   sp_gain_reg   <= cfg_wdata[ptph_pkg::SPG_W-1:0];
                ptph_pkg::REG_SETPOINT_OFFSET: sp_offset_reg <= cfg_wdata[ptph_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= 1'b0;
            slot_reg      <= '0;
            integral_reg  <= '0;
            last_meas_reg <= '0;
            control_reg   <= '0;
            held_sp_reg   <= '0;
            held_err_reg  <= '0;
            csw_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (state_reg == ST_RESULT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        tick_reg      <= (s_tuser == ptph_pkg::FUNC_TICK);
                        meas_reg      <= s_tdata[ptph_pkg::RAW_W-1:1];
                        sp_mcand_reg  <= ptph_pkg::SPPROD_W'(s_tdata[2*ptph_pkg::RAW_W-1:ptph_pkg::RAW_W]);
                        sp_mplier_reg <= sp_gain_reg;
                        sp_acc_reg    <= '0;
                        cnt_reg       <= CNT_W'(ptph_pkg::SPG_W - 1);
                        state_reg     <= (s_tuser == ptph_pkg::FUNC_TICK) ? ST_RESULT : ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    if (sp_mplier_reg[0]) begin
                        sp_acc_reg <= sp_acc_reg + sp_mcand_reg;
                    end
                    sp_mcand_reg  <= sp_mcand_reg << 1;
                    sp_mplier_reg <= sp_mplier_reg >> 1;
                    cnt_reg       <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_ERROR;
                    end
                end
                ST_ERROR: begin
                    held_sp_reg   <= sp_next;
                    held_err_reg  <= err_next;
                    last_meas_reg <= meas_reg;
                    err_sh_reg    <= {{(ptph_pkg::TERM_W-ptph_pkg::ERR_W){err_next[ptph_pkg::ERR_W-1]}},
                                      err_next};
                    diff_sh_reg   <= {{(ptph_pkg::TERM_W-ptph_pkg::DIFF_W){diff_next[ptph_pkg::DIFF_W-1]}},
                                      diff_next};
                    gp_sh_reg     <= gain_p_reg;
                    gi_sh_reg     <= gain_i_reg;
                    gd_sh_reg     <= gain_d_reg;
                    p_acc_reg     <= '0;
                    i_acc_reg     <= '0;
                    d_acc_reg     <= '0;
                    cnt_reg       <= CNT_W'(ptph_pkg::GAIN_W - 1);
                    state_reg     <= ST_TERMS;
                end
                ST_TERMS: begin
                    if (gp_sh_reg[0]) begin
                        p_acc_reg <= p_acc_reg + err_sh_reg;
                    end
                    if (gi_sh_reg[0]) begin
                        i_acc_reg <= i_acc_reg + err_sh_reg;
                    end
                    if (gd_sh_reg[0]) begin
                        d_acc_reg <= d_acc_reg + diff_sh_reg;
                    end
                    err_sh_reg  <= err_sh_reg <<< 1;
                    diff_sh_reg <= diff_sh_reg <<< 1;
                    gp_sh_reg   <= gp_sh_reg >> 1;
                    gi_sh_reg   <= gi_sh_reg >> 1;
                    gd_sh_reg   <= gd_sh_reg >> 1;
                    cnt_reg     <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    p_sat_reg    <= sat16({p_acc_reg[19], p_acc_reg});
                    d_sat_reg    <= sat16({d_acc_reg[19], d_acc_reg});
                    integral_reg <= sat16(integral_sum);
                    state_reg    <= ST_CTRL;
                end
                ST_CTRL: begin
                    control_reg <= sat16(control_sum);
                    state_reg   <= ST_THRESH;
                end
                ST_THRESH: begin
                    csw_reg   <= csw_next;
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {4'b0000,
                                         control_reg,
                                         {{(ptph_pkg::VAL_W-ptph_pkg::ERR_W){held_err_reg[ptph_pkg::ERR_W-1]}},
                                          held_err_reg},
                                         last_meas_reg,
                                         held_sp_reg,
                                         heater_next};
                        if (tick_reg) begin
                            slot_reg <= slot_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_slot_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg < SLOT_W'(WINDOW_SLOTS))
        else $error("slot counter left the window");

    a_tick_short_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == ptph_pkg::FUNC_TICK) |=> (state_reg == ST_RESULT))
        else $error("tick request did not go straight to the result stage");

    a_csw_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        csw_reg <= PROD_W'(CONTROL_FULL_SCALE * WINDOW_SLOTS))
        else $error("threshold weight above full scale");

    a_control_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CTRL) |=> $stable(control_reg))
        else $error("control value changed outside the sum stage");

    a_slot_held_on_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && !tick_reg) |=> $stable(slot_reg))
        else $error("slot advanced on a sample request");

endmodule

### test/tb_pid_time_proportional_heater.sv
// ----------------------------------------------------------------------------
// tb_pid_time_proportional_heater: self-checking bench for the PID heater
// Drives tick and sample requests on the slave stream and checks every result
// request on the master stream, field by field, against an in-bench model of
// the controller. It opens with a directed table of requests and register
// writes, then runs random phases under several register settings. Both
// stream sides idle and stall at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_pid_time_proportional_heater;

    localparam int WINDOW_SLOTS       = 19;
    localparam int CONTROL_FULL_SCALE = 1020;
    localparam int HALF_PERIOD        = 5;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int PHASES             = 8;
    localparam int PHASE_REQUESTS     = 80;
    localparam int HOLD_CYCLES        = 200;
    localparam int SP_FRAC_BITS       = 10;
    localparam int SP_MAX             = 1023;
    localparam int VAL_MAX            = 32767;
    localparam int VAL_MIN            = -32768;

    localparam logic [ptph_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [ptph_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd6;
    localparam logic [ptph_pkg::CFG_ADDR_W-1:0] REG_SPARE_C = 3'd7;

    typedef struct packed {
        logic signed [ptph_pkg::VAL_W-1:0] control_value;
        logic signed [ptph_pkg::VAL_W-1:0] error_value;
        logic [ptph_pkg::MEAS_W-1:0]       measured;
        logic [ptph_pkg::SP_W-1:0]         setpoint_scaled;
        logic                              heater_on;
    } result_t;

    typedef enum logic {
        ROW_REQUEST = 1'b0,
        ROW_WRITE   = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [ptph_pkg::CFG_ADDR_W-1:0] addr;
        logic [ptph_pkg::CFG_DATA_W-1:0] wdata;
        ptph_pkg::func_t                 func;
        logic [ptph_pkg::RAW_W-1:0]      meas_raw;
        logic [ptph_pkg::RAW_W-1:0]      sp_raw;
        logic                            typed;
        logic                            typed_heater;
    } row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_we;
    logic [ptph_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [ptph_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    // [9:0] measured_raw, [19:10] setpoint_raw, [23:20] zero
    logic [ptph_pkg::S_DATA_W-1:0]   s_tdata;
    // [0] func
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    // [0] heater_on, [10:1] setpoint_scaled, [19:11] measured,
    // [35:20] error_value, [51:36] control_value, [55:52] zero
    logic [ptph_pkg::M_DATA_W-1:0]   m_tdata;

    // model registers and state
    int kp = 1, ki = 1, kd = 1, sp_gain = 48, sp_offset = 32;
    int win_slot = 0, integ_acc = 0, last_meas = 0, ctrl_out = 0;
    int held_sp = 0, held_err = 0;

    result_t pending_results[$];
    row_t    directed_plan[$];
    int      failures = 0;
    int      cycle_count = 0;
    bit      src_idle = 1'b1;
    bit      sink_idle = 1'b1;
    int      sink_hold = 0;

    pid_time_proportional_heater #(
        .WINDOW_SLOTS      (WINDOW_SLOTS),
        .CONTROL_FULL_SCALE(CONTROL_FULL_SCALE)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic int clip16(input int v);
        if (v > VAL_MAX) return VAL_MAX;
        if (v < VAL_MIN) return VAL_MIN;
        return v;
    endfunction

    function automatic result_t heater_step(input ptph_pkg::func_t kind,
                                            input logic [ptph_pkg::RAW_W-1:0] meas_raw,
                                            input logic [ptph_pkg::RAW_W-1:0] sp_raw);
        result_t r;
        int      meas, sp, err, p_term, d_term, level;
        logic    heat;
        if (kind == ptph_pkg::FUNC_SAMPLE) begin
            meas = int'(meas_raw[ptph_pkg::RAW_W-1:1]);
            sp = ((int'(sp_raw) * sp_gain) >>> SP_FRAC_BITS) + sp_offset;
            if (sp > SP_MAX) sp = SP_MAX;
            err = sp - meas;
            p_term = clip16(err * kp);
            integ_acc = clip16(integ_acc + err * ki);
            d_term = clip16((last_meas - meas) * kd);
            last_meas = meas;
            ctrl_out = clip16(p_term + integ_acc + d_term);
            held_sp = sp;
            held_err = err;
        end
        level = (ctrl_out < 0) ? 0 :
                (ctrl_out > CONTROL_FULL_SCALE) ? CONTROL_FULL_SCALE : ctrl_out;
        heat = (win_slot <= level * WINDOW_SLOTS / CONTROL_FULL_SCALE);
        if (kind == ptph_pkg::FUNC_TICK) begin
            win_slot = win_slot + 1;
            if (win_slot >= WINDOW_SLOTS) win_slot = 0;
        end
        r.heater_on       = heat;
        r.setpoint_scaled = held_sp[ptph_pkg::SP_W-1:0];
        r.measured        = last_meas[ptph_pkg::MEAS_W-1:0];
        r.error_value     = held_err[ptph_pkg::VAL_W-1:0];
        r.control_value   = ctrl_out[ptph_pkg::VAL_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function automatic void add_request(input ptph_pkg::func_t f,
                                        input logic [ptph_pkg::RAW_W-1:0] mr,
                                        input logic [ptph_pkg::RAW_W-1:0] sr,
                                        input logic typed, input logic heat);
        row_t row;
        row = '0;
        row.kind = ROW_REQUEST;
        row.func = f;
        row.meas_raw = mr;
        row.sp_raw = sr;
        row.typed = typed;
        row.typed_heater = heat;
        directed_plan.push_back(row);
    endfunction

    function automatic void add_write(input logic [ptph_pkg::CFG_ADDR_W-1:0] addr,
                                      input logic [ptph_pkg::CFG_DATA_W-1:0] wdata);
        row_t row;
        row = '0;
        row.kind = ROW_WRITE;
        row.addr = addr;
        row.wdata = wdata;
        directed_plan.push_back(row);
    endfunction

    task automatic cfg_write(input logic [ptph_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [ptph_pkg::CFG_DATA_W-1:0] wdata);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= wdata;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (addr)
            ptph_pkg::REG_GAIN_P:          kp = int'(wdata[ptph_pkg::GAIN_W-1:0]);
            ptph_pkg::REG_GAIN_I:          ki = int'(wdata[ptph_pkg::GAIN_W-1:0]);
            ptph_pkg::REG_GAIN_D:          kd = int'(wdata[ptph_pkg::GAIN_W-1:0]);
            ptph_pkg::REG_SETPOINT_GAIN:   sp_gain = int'(wdata[ptph_pkg::SPG_W-1:0]);
            ptph_pkg::REG_SETPOINT_OFFSET: sp_offset = int'(wdata[ptph_pkg::GAIN_W-1:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_request(input ptph_pkg::func_t kind,
                                input logic [ptph_pkg::RAW_W-1:0] mr,
                                input logic [ptph_pkg::RAW_W-1:0] sr, input int gap,
                                input logic typed, input result_t typed_res);
        result_t predicted;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(ptph_pkg::S_DATA_W - 2 * ptph_pkg::RAW_W){1'b0}}, sr, mr};
        do @(posedge aclk); while (!s_tready);
        predicted = heater_step(kind, mr, sr);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic int src_gap();
        return src_idle ? int'($urandom_range(0, 10)) : 0;
    endfunction

    function automatic logic [ptph_pkg::CFG_DATA_W-1:0] random_gain();
        return $urandom_range(0, 1) ? 10'($urandom_range(0, 6))
                                    : 10'($urandom_range(0, 1023));
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        result_t got, want;
        if (m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (pending_results.size() == 0) begin
                $error("unexpected result request: %h", got);
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("heater_on", want.heater_on, got.heater_on);
                check_field("setpoint_scaled", want.setpoint_scaled, got.setpoint_scaled);
                check_field("measured", want.measured, got.measured);
                check_field("error_value", want.error_value, got.error_value);
                check_field("control_value", want.control_value, got.control_value);
            end
        end
    end

    initial begin
        int gap;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            gap = sink_idle ? int'($urandom_range(0, 10)) : 0;
            if (sink_hold > 0) begin
                gap = sink_hold;
                sink_hold = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        result_t                    typed_res;
        ptph_pkg::func_t            kind;
        logic [ptph_pkg::RAW_W-1:0] mr, sr;
        int                         burst_left, sp_est, near;

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ptph_pkg::FUNC_TICK;
        s_tdata   <= '0;

        // reset state: control zero, so only slot 0 drives the heater
        add_request(ptph_pkg::FUNC_TICK, 10'h000, 10'h000, 1'b1, 1'b1);
        add_request(ptph_pkg::FUNC_TICK, 10'h3FF, 10'h3FF, 1'b1, 1'b0);
        add_write(REG_SPARE_A, 10'h3FF);
        add_write(REG_SPARE_B, 10'h000);
        add_write(REG_SPARE_C, 10'h155);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h000, 10'h000, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h3FF, 10'h3FF, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h2AA, 10'h155, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h155, 10'h2AA, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_TICK, 10'h155, 10'h2AA, 1'b0, 1'b0);
        // full gains: setpoint clamps, terms saturate both ways, integral saturates high
        add_write(ptph_pkg::REG_GAIN_P, 10'h3FF);
        add_write(ptph_pkg::REG_GAIN_I, 10'h3FF);
        add_write(ptph_pkg::REG_GAIN_D, 10'h3FF);
        add_write(ptph_pkg::REG_SETPOINT_GAIN, 10'h3FF);
        add_write(ptph_pkg::REG_SETPOINT_OFFSET, 10'h3FF);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h000, 10'h3FF, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h000, 10'h3FF, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h3FF, 10'h000, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h000, 10'h000, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_TICK, 10'h000, 10'h000, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_TICK, 10'h000, 10'h000, 1'b0, 1'b0);
        add_write(ptph_pkg::REG_GAIN_P, 10'h000);
        add_write(ptph_pkg::REG_GAIN_I, 10'h000);
        add_write(ptph_pkg::REG_GAIN_D, 10'h000);
        add_write(ptph_pkg::REG_SETPOINT_GAIN, 10'h000);
        add_write(ptph_pkg::REG_SETPOINT_OFFSET, 10'h000);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h3FF, 10'h3FF, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_TICK, 10'h3FF, 10'h3FF, 1'b0, 1'b0);
        // upper data bits dropped on the narrow registers
        add_write(ptph_pkg::REG_GAIN_P, 10'h301);
        add_write(ptph_pkg::REG_GAIN_I, 10'h2FF);
        add_write(ptph_pkg::REG_GAIN_D, 10'h101);
        add_write(ptph_pkg::REG_SETPOINT_GAIN, 10'd48);
        add_write(ptph_pkg::REG_SETPOINT_OFFSET, 10'h120);
        // drive the integral to negative saturation, then tick on a negative control
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h3FF, 10'h000, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h3FF, 10'h000, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_SAMPLE, 10'h3FF, 10'h000, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_TICK, 10'h000, 10'h000, 1'b0, 1'b0);
        add_request(ptph_pkg::FUNC_TICK, 10'h000, 10'h000, 1'b0, 1'b0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == ROW_WRITE) begin
                wait_results_done();
                cfg_write(directed_plan[k].addr, directed_plan[k].wdata);
            end else begin
                typed_res = '0;
                typed_res.heater_on = directed_plan[k].typed_heater;
                send_request(directed_plan[k].func, directed_plan[k].meas_raw,
                             directed_plan[k].sp_raw, src_gap(),
                             directed_plan[k].typed, typed_res);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_results_done();
            case (p)
                0: begin
                    cfg_write(ptph_pkg::REG_GAIN_P, 10'd1);
                    cfg_write(ptph_pkg::REG_GAIN_I, 10'd1);
                    cfg_write(ptph_pkg::REG_GAIN_D, 10'd1);
                    cfg_write(ptph_pkg::REG_SETPOINT_GAIN, 10'd48);
                    cfg_write(ptph_pkg::REG_SETPOINT_OFFSET, 10'd32);
                end
                1: begin
                    cfg_write(ptph_pkg::REG_GAIN_P, 10'd255);
                    cfg_write(ptph_pkg::REG_GAIN_I, 10'd255);
                    cfg_write(ptph_pkg::REG_GAIN_D, 10'd255);
                    cfg_write(ptph_pkg::REG_SETPOINT_GAIN, 10'd1023);
                    cfg_write(ptph_pkg::REG_SETPOINT_OFFSET, 10'd255);
                end
                2: begin
                    cfg_write(ptph_pkg::REG_GAIN_P, 10'd0);
                    cfg_write(ptph_pkg::REG_GAIN_I, 10'd0);
                    cfg_write(ptph_pkg::REG_GAIN_D, 10'd0);
                    cfg_write(ptph_pkg::REG_SETPOINT_GAIN, 10'd0);
                    cfg_write(ptph_pkg::REG_SETPOINT_OFFSET, 10'd0);
                end
                default: begin
                    cfg_write(ptph_pkg::REG_GAIN_P, random_gain());
                    cfg_write(ptph_pkg::REG_GAIN_I, random_gain());
                    cfg_write(ptph_pkg::REG_GAIN_D, random_gain());
                    cfg_write(ptph_pkg::REG_SETPOINT_GAIN, 10'($urandom_range(0, 1023)));
                    cfg_write(ptph_pkg::REG_SETPOINT_OFFSET, 10'($urandom_range(0, 1023)));
                end
            endcase
            src_idle  = (p % 4 == 0) || (p % 4 == 1);
            sink_idle = (p % 4 == 0) || (p % 4 == 2);
            burst_left = 0;
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                kind = ($urandom_range(0, 99) < 55) ? ptph_pkg::FUNC_TICK
                                                    : ptph_pkg::FUNC_SAMPLE;
                mr = 10'($urandom_range(0, 1023));
                sr = 10'($urandom_range(0, 1023));
                // keep the reading close to the setpoint so control stays in band
                if (kind == ptph_pkg::FUNC_SAMPLE && $urandom_range(0, 2) != 0) begin
                    sp_est = ((int'(sr) * sp_gain) >>> SP_FRAC_BITS) + sp_offset;
                    if (sp_est > SP_MAX) sp_est = SP_MAX;
                    near = 2 * sp_est + int'($urandom_range(0, 40)) - 20;
                    if (near < 0) near = 0;
                    if (near > 1023) near = 1023;
                    mr = near[ptph_pkg::RAW_W-1:0];
                end
                if (p == 4 && i == 20) begin
                    sink_hold = HOLD_CYCLES;
                    burst_left = 15;
                end
                if (burst_left > 0) begin
                    burst_left--;
                    send_request(kind, mr, sr, 0, 1'b0, '0);
                end else begin
                    send_request(kind, mr, sr, src_gap(), 1'b0, '0);
                end
            end
        end

        wait_results_done();
        repeat (40) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ptph_pkg.sv
hw/rtl/pid_time_proportional_heater.sv
test/tb_pid_time_proportional_heater.sv
